// File: rtl/core/u8c6_pkg.sv
package u8c6_pkg;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  localparam int unsigned CpW      = 31;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 3;
  localparam int unsigned RegW     = 32;
  localparam int unsigned AddrW    = 3;

  // register index of the direction register
  localparam logic [0:0] REG_DIRECTION = 1'b0;

  // sequence length bounds
  localparam logic [CpW-1:0] BOUND_1 = 31'd128;
  localparam logic [CpW-1:0] BOUND_2 = 31'd2048;
  localparam logic [CpW-1:0] BOUND_3 = 31'd65536;
  localparam logic [CpW-1:0] BOUND_4 = 31'd2097152;
  localparam logic [CpW-1:0] BOUND_5 = 31'd67108864;

  localparam logic [ByteW-1:0] LEAD_2    = 8'hC0;
  localparam logic [ByteW-1:0] LEAD_3    = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_4    = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_5    = 8'hF8;
  localparam logic [ByteW-1:0] LEAD_6    = 8'hFC;
  localparam logic [ByteW-1:0] CONT_TAG  = 8'h80;
  localparam logic [ByteW-1:0] CONT_MASK = 8'h3F;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [ByteW-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_byte;
    logic [CpW-1:0]   decoded_value;
    logic             bad_sequence;
  } out_item_t;

endpackage

// File: rtl/core/utf8_six_byte_codec_unit.sv
// channel | direction | handshake             | beat
// in      | into      | in_valid_i/in_stall_o   | in_item_i (code point or byte)
// out     | out of    | out_valid_o/out_stall_i | out_item_o (byte or code point)
// cfg     | into      | apb psel/penable/pready | direction at byte address 0
//
// an accepted item sits in the item register and gives one result beat a cycle
// into the output register while the output is not stalled: an encoded code
// point gives 1 to 6 beats, a decoded byte 0 or 1 beat (0 beats mid-sequence,
// 1 beat on an early lead byte), 2 beats for an ascii byte that cuts a sequence short
// the next item is taken in the cycle its predecessor's last beat goes out
// a stall on the output holds the output register and then backs up the input
// reset clears direction (encode), the decode state and both valid flags
module utf8_six_byte_codec_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  u8c6_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output u8c6_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [u8c6_pkg::AddrW-1:0]  paddr,
  input  logic [u8c6_pkg::RegW-1:0]   pwdata,
  output logic [u8c6_pkg::RegW-1:0]   prdata,
  output logic                        pready
);
  import u8c6_pkg::*;

  dir_e             direction_q;
  logic             item_valid_q;
  in_item_t         item_q;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CpW-1:0]   partial_q, partial_d;
  logic [CntW-1:0]  owed_q, owed_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  logic             accept, push, done;
  logic [CntW-1:0]  res_cnt;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIRECTION) ?
                  {31'b0, direction_q == DIR_DECODE} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENCODE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
      direction_q <= dir_e'(pwdata[0]);
    end
  end

  // encode side
  logic [CntW-1:0]  enc_cnt, enc_grp;
  logic [ByteW-1:0] enc_lead, enc_slice, enc_byte;
  logic [CpW-1:0]   cp;

  assign cp = item_q.code_point;

  always_comb begin
    if (cp < BOUND_1) begin
      enc_cnt = 3'd1; enc_lead = '0;
    end else if (cp < BOUND_2) begin
      enc_cnt = 3'd2; enc_lead = LEAD_2;
    end else if (cp < BOUND_3) begin
      enc_cnt = 3'd3; enc_lead = LEAD_3;
    end else if (cp < BOUND_4) begin
      enc_cnt = 3'd4; enc_lead = LEAD_4;
    end else if (cp < BOUND_5) begin
      enc_cnt = 3'd5; enc_lead = LEAD_5;
    end else begin
      enc_cnt = 3'd6; enc_lead = LEAD_6;
    end
  end

  // six-bit group still to send, counted from the low end
  assign enc_grp = enc_cnt - 3'd1 - idx_q;

  always_comb begin
    case (enc_grp)
      3'd0:    enc_slice = cp[7:0];
      3'd1:    enc_slice = cp[13:6];
      3'd2:    enc_slice = cp[19:12];
      3'd3:    enc_slice = cp[25:18];
      3'd4:    enc_slice = {1'b0, cp[30:24]};
      3'd5:    enc_slice = {7'b0, cp[30]};
      default: enc_slice = '0;
    endcase
  end

  assign enc_byte = (idx_q == '0) ? (enc_lead | enc_slice)
                                  : (CONT_TAG | (enc_slice & CONT_MASK));

  // decode side
  logic [ByteW-1:0] b;
  logic             is_ascii, is_cont, is_ff, is_lead;
  logic [CpW-1:0]   lead_pv, cont_pv;
  logic [CntW-1:0]  lead_owed, dec_cnt;
  logic [CpW-1:0]   r0_val, r1_val;
  logic             r0_bad;

  assign b        = item_q.in_byte;
  assign is_ascii = !b[7];
  assign is_cont  = b[7:6] == 2'b10;
  assign is_ff    = b[7:1] == 7'h7F;
  assign is_lead  = b[7:6] == 2'b11 && !is_ff;
  assign cont_pv  = {partial_q[24:0], b[5:0]};

  always_comb begin
    if (!b[5]) begin
      lead_pv = {26'b0, b[4:0]}; lead_owed = 3'd1;
    end else if (!b[4]) begin
      lead_pv = {27'b0, b[3:0]}; lead_owed = 3'd2;
    end else if (!b[3]) begin
      lead_pv = {28'b0, b[2:0]}; lead_owed = 3'd3;
    end else if (!b[2]) begin
      lead_pv = {29'b0, b[1:0]}; lead_owed = 3'd4;
    end else begin
      lead_pv = {30'b0, b[0]};   lead_owed = 3'd5;
    end
  end

  always_comb begin
    partial_d = partial_q;
    owed_d    = owed_q;
    dec_cnt   = '0;
    r0_val    = '0;
    r0_bad    = 1'b0;
    r1_val    = '0;
    if (owed_q == '0) begin
      if (is_ascii) begin
        dec_cnt = 3'd1;
        r0_val  = {23'b0, b};
      end else if (is_lead) begin
        partial_d = lead_pv;
        owed_d    = lead_owed;
      end else begin
        dec_cnt = 3'd1;
        r0_bad  = 1'b1;
      end
    end else if (is_cont) begin
      partial_d = cont_pv;
      owed_d    = owed_q - 3'd1;
      if (owed_q == 3'd1) begin
        dec_cnt = 3'd1;
        r0_val  = cont_pv;
      end
    end else begin
      // sequence cut short: flag it, then take the byte afresh
      partial_d = '0;
      owed_d    = '0;
      r0_bad    = 1'b1;
      if (is_ascii) begin
        dec_cnt = 3'd2;
        r1_val  = {23'b0, b};
      end else if (is_lead) begin
        dec_cnt   = 3'd1;
        partial_d = lead_pv;
        owed_d    = lead_owed;
      end else begin
        dec_cnt = 3'd1;
      end
    end
  end

  // result sequencing
  assign res_cnt = (direction_q == DIR_ENCODE) ? enc_cnt : dec_cnt;

  always_comb begin
    out_d.last_byte = idx_q == res_cnt - 3'd1;
    if (direction_q == DIR_ENCODE) begin
      out_d.out_byte      = enc_byte;
      out_d.decoded_value = '0;
      out_d.bad_sequence  = 1'b0;
    end else begin
      out_d.out_byte      = '0;
      out_d.decoded_value = (idx_q == '0) ? r0_val : r1_val;
      out_d.bad_sequence  = (idx_q == '0) ? r0_bad : 1'b0;
    end
  end

  assign push       = item_valid_q && res_cnt != '0 && (!out_valid_q || !out_stall_i);
  assign done       = item_valid_q && (res_cnt == '0 || (push && out_d.last_byte));
  assign in_stall_o = item_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_d      = done ? '0 : (push ? idx_q + 3'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      idx_q        <= '0;
      partial_q    <= '0;
      owed_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (done) begin
        item_valid_q <= 1'b0;
      end
      if (done && direction_q == DIR_DECODE) begin
        partial_q <= partial_d;
        owed_q    <= owed_d;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_owed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= 3'd5)
    else $error("bytes owed out of range");

  a_idx_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && res_cnt != '0 |-> idx_q < res_cnt)
    else $error("result index past item end");

  a_bad_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_sequence |->
      out_item_o.decoded_value == '0 && out_item_o.out_byte == '0)
    else $error("error beat carries data");

  a_no_beat_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && res_cnt == '0 |=> !$rose(out_valid_q) || $past(push))
    else $error("beat pushed for an item with no result");

endmodule

// File: dv/tb_utf8_six_byte_codec_unit.sv
`timescale 1ns / 1ps

module tb_utf8_six_byte_codec_unit;
  import u8c6_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 8;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // six-byte sequence with the largest value
  logic [7:0] push_byte_list[6] = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};

  utf8_six_byte_codec_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // model state of the codec
  dir_e            dir_q = DIR_ENCODE;
  logic [CpW-1:0]  gathered_cp = '0;
  logic [CntW-1:0] cont_owed = '0;

  in_item_t  source_items[$];
  out_item_t predicted_beats[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned in_beats = 0;
  int unsigned out_beats = 0;
  int unsigned mismatches = 0;

  function automatic void push_beat(input logic [7:0] ob, input logic last,
                                    input logic [CpW-1:0] val, input logic bad);
    out_item_t r;
    r.out_byte      = ob;
    r.last_byte     = last;
    r.decoded_value = val;
    r.bad_sequence  = bad;
    predicted_beats = {predicted_beats, r};
  endfunction

  function automatic void encode_point(input logic [CpW-1:0] cp);
    int n;
    logic [7:0] lead;
    logic [CpW-1:0] part;
    if (cp < BOUND_1) begin
      push_beat(cp[7:0], 1'b1, '0, 1'b0);
      return;
    end
    if (cp < BOUND_2) begin
      n = 2; lead = LEAD_2;
    end else if (cp < BOUND_3) begin
      n = 3; lead = LEAD_3;
    end else if (cp < BOUND_4) begin
      n = 4; lead = LEAD_4;
    end else if (cp < BOUND_5) begin
      n = 5; lead = LEAD_5;
    end else begin
      n = 6; lead = LEAD_6;
    end
    for (int i = 0; i < n; i++) begin
      part = cp >> (6 * (n - 1 - i));
      if (i == 0) push_beat(lead | part[7:0], 1'b0, '0, 1'b0);
      else push_beat(CONT_TAG | (part[7:0] & CONT_MASK), i == n - 1, '0, 1'b0);
    end
  endfunction

  // byte seen with no sequence open; returns 1 if it gave a beat
  function automatic bit fresh_byte(input logic [7:0] b, input bit fold_error);
    if (b < CONT_TAG) begin
      push_beat('0, 1'b1, CpW'(b), 1'b0);
      return 1'b1;
    end
    if (b < LEAD_2 || b >= 8'hFE) begin
      if (!fold_error) push_beat('0, 1'b1, '0, 1'b1);
      return !fold_error;
    end
    if (b < LEAD_3) begin
      gathered_cp = CpW'(b[4:0]); cont_owed = 3'd1;
    end else if (b < LEAD_4) begin
      gathered_cp = CpW'(b[3:0]); cont_owed = 3'd2;
    end else if (b < LEAD_5) begin
      gathered_cp = CpW'(b[2:0]); cont_owed = 3'd3;
    end else if (b < LEAD_6) begin
      gathered_cp = CpW'(b[1:0]); cont_owed = 3'd4;
    end else begin
      gathered_cp = CpW'(b[0]); cont_owed = 3'd5;
    end
    return 1'b0;
  endfunction

  function automatic void codec_step(input in_item_t it);
    logic [7:0] b;
    int err_idx;
    b = it.in_byte;
    if (dir_q == DIR_ENCODE) begin
      encode_point(it.code_point);
    end else if (cont_owed == '0) begin
      void'(fresh_byte(b, 1'b0));
    end else if (b[7:6] == 2'b10) begin
      gathered_cp = {gathered_cp[CpW-7:0], b[5:0]};
      cont_owed = cont_owed - 3'd1;
      if (cont_owed == '0) push_beat('0, 1'b1, gathered_cp, 1'b0);
    end else begin
      // early non-continuation: flag, then take the byte afresh
      gathered_cp = '0;
      cont_owed = '0;
      err_idx = predicted_beats.size();
      push_beat('0, 1'b1, '0, 1'b1);
      if (fresh_byte(b, 1'b1)) predicted_beats[err_idx].last_byte = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_beats++;
        codec_step(in_item);
      end
      if (!in_valid || !in_stall) begin
        if (source_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item <= source_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $realtime, field, want, got);
    mismatches++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_beats++;
        if (predicted_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %p", $realtime, out_item);
          mismatches++;
        end else begin
          want = predicted_beats.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report("out_byte", 32'(want.out_byte), 32'(out_item.out_byte));
          if (out_item.last_byte !== want.last_byte)
            report("last_byte", 32'(want.last_byte), 32'(out_item.last_byte));
          if (out_item.decoded_value !== want.decoded_value)
            report("decoded_value", 32'(want.decoded_value),
                   32'(out_item.decoded_value));
          if (out_item.bad_sequence !== want.bad_sequence)
            report("bad_sequence", 32'(want.bad_sequence), 32'(out_item.bad_sequence));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on beats moving in either direction
  initial begin
    int unsigned quiet;
    int unsigned seen;
    quiet = 0;
    seen = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk_i);
      if (in_beats + out_beats != seen) begin
        seen = in_beats + out_beats;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_cp(input logic [CpW-1:0] cp);
    in_item_t it;
    it.code_point = cp;
    it.in_byte = 8'($urandom);
    source_items = {source_items, it};
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.code_point = CpW'($urandom);
    it.in_byte = b;
    source_items = {source_items, it};
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (source_items.size() != 0 || in_valid || predicted_beats.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_direction(input dir_e d);
    drain();
    // a mid-sequence byte gives no beat, so let it settle
    repeat (SettleCycles) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_DIRECTION);
    pwdata <= 32'(d);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dir_q = d;
  endtask

  task automatic queue_encode_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: push_cp(CpW'($urandom_range(127)));
        1: push_cp(CpW'($urandom_range(2047, 128)));
        2: push_cp(CpW'($urandom_range(65535, 2048)));
        3: push_cp(CpW'($urandom_range(2097151, 65536)));
        4: push_cp(CpW'($urandom_range(67108863, 2097152)));
        default: push_cp(CpW'($urandom_range(32'h7FFF_FFFF, 67108864)));
      endcase
    end
  endtask

  task automatic queue_decode_random(input int min_bytes);
    int count;
    int pick;
    int n;
    int conts;
    logic [7:0] lead;
    count = 0;
    while (count < min_bytes) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        push_byte(8'hFE | 8'($urandom_range(1)));
        count++;
      end else if (pick < 14) begin
        push_byte(8'($urandom_range(255)));
        count++;
      end else begin
        n = $urandom_range(6, 1);
        case (n)
          1: lead = 8'($urandom_range(127));
          2: lead = LEAD_2 | 8'($urandom_range(31));
          3: lead = LEAD_3 | 8'($urandom_range(15));
          4: lead = LEAD_4 | 8'($urandom_range(7));
          5: lead = LEAD_5 | 8'($urandom_range(3));
          default: lead = LEAD_6 | 8'($urandom_range(1));
        endcase
        push_byte(lead);
        count++;
        conts = n - 1;
        // cut some sequences short
        if (pick < 26 && conts > 0) conts = $urandom_range(conts - 1);
        for (int k = 0; k < conts; k++) begin
          push_byte(CONT_TAG | 8'($urandom_range(63)));
          count++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    send_idle = 38;
    recv_idle = 55;

    // encode extremes and length bounds, reset direction
    push_cp(31'd0);
    push_cp(31'd127);
    push_cp(31'd128);
    push_cp(31'd2047);
    push_cp(31'd65535);
    push_cp(31'd65536);
    push_cp(31'd2097152);
    push_cp(31'd67108863);
    push_cp(31'h7FFF_FFFF);
    push_cp(31'h2AAA_AAAA);

    set_direction(DIR_DECODE);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);   // stray continuation
    push_byte(8'hFE);
    push_byte(8'hFF);
    push_byte(8'hC0);   // overlong zero
    push_byte(8'h80);
    foreach (push_byte_list[i]) push_byte(push_byte_list[i]);
    push_byte(8'hE2);   // early ascii
    push_byte(8'h41);
    push_byte(8'hE2);   // early lead
    push_byte(8'hC3);
    push_byte(8'hA9);
    push_byte(8'hF0);   // early 0xff
    push_byte(8'hFF);
    push_byte(8'hE2);   // left open across an encode phase
    push_byte(8'h82);
    set_direction(DIR_ENCODE);
    push_cp(31'h0000_20AC);
    set_direction(DIR_DECODE);
    push_byte(8'hAC);

    // random part, with a sender pause in the middle of the first decode phase
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 38 : (p == 1) ? 55 : 0;
      recv_idle = (p == 0) ? 55 : (p == 1) ? 38 : 0;
      set_direction(DIR_ENCODE);
      queue_encode_random(16);
      set_direction(DIR_DECODE);
      queue_decode_random(12);
      if (p == 0) drain();
      queue_decode_random(12);
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && predicted_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
